// ===== rtl/vcs_pkg.sv =====
// Shared types, constants and register codes of the velocity command smoother.
package vcs_pkg;

    localparam int VEL_W       = 16;
    localparam int SPEED_W     = 15;
    localparam int ACCEL_W     = 16;
    localparam int DT_W        = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int BAND_W      = 12;
    localparam int ALU_A_W     = 32;
    localparam int ALU_B_W     = 32;
    localparam int ALU_RES_W   = 48;
    localparam int QUOT_W      = 15;
    localparam int SQ_W        = 30;

    localparam logic [BAND_W-1:0]  FWD_BAND_DEF     = BAND_W'(20);
    localparam logic [BAND_W-1:0]  SIDE_BAND_DEF    = BAND_W'(20);
    localparam logic [BAND_W-1:0]  YAW_BAND_DEF     = BAND_W'(20);
    localparam logic [ACCEL_W-1:0] STEP_FLOOR       = ACCEL_W'(41);
    localparam logic [SPEED_W-1:0] DECOUPLE_MIN     = SPEED_W'(4);

    localparam logic [CFG_IDX_W-1:0] CFG_FWD_SPEED_LIM     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SIDE_SPEED_LIM    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_YAW_SPEED_LIM     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINEAR_ACCEL  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LATERAL_ACCEL = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGULAR_ACCEL = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_DECOUPLE_ENABLE   = 3'd6;

    typedef logic signed [VEL_W-1:0] t_vel;

    typedef struct packed {
        logic signed [VEL_W-1:0] target_linear_x;
        logic signed [VEL_W-1:0] target_lateral_y;
        logic signed [VEL_W-1:0] target_angular_z;
        logic [DT_W-1:0]         step_time;
        logic                    restart;
    } t_cmd_in;

    typedef struct packed {
        logic signed [VEL_W-1:0] out_linear_x;
        logic signed [VEL_W-1:0] out_lateral_y;
        logic signed [VEL_W-1:0] out_angular_z;
    } t_cmd_out;

    typedef struct packed {
        logic [SPEED_W-1:0] fwd_speed_lim;
        logic [SPEED_W-1:0] side_speed_lim;
        logic [SPEED_W-1:0] yaw_speed_lim;
        logic [ACCEL_W-1:0] max_linear_accel;
        logic [ACCEL_W-1:0] max_lateral_accel;
        logic [ACCEL_W-1:0] max_angular_accel;
        logic               lateral_decoupling_enable;
    } t_cfg;

    typedef enum logic [0:0] {
        ALU_MUL,
        ALU_DIV
    } t_alu_op;

    typedef struct packed {
        t_alu_op              op;
        logic [ALU_A_W-1:0]   a;
        logic [ALU_B_W-1:0]   b;
    } t_alu_req;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLAMP,
        ST_SQ_MAX,
        ST_SQ_YAW,
        ST_MUL_LAT,
        ST_LOAD_DIV,
        ST_DIV,
        ST_DIV_LAST,
        ST_ROUTE,
        ST_MUL_STEP,
        ST_SLEW,
        ST_FINISH
    } t_state;

endpackage

// ===== rtl/vcs_cfg_regs.sv =====
// Configuration register file of the velocity command smoother.
module vcs_cfg_regs (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [vcs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [vcs_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    output vcs_pkg::t_cfg                    o_cfg
);

    vcs_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fwd_speed_lim             <= vcs_pkg::SPEED_W'(4096);
            r_cfg.side_speed_lim            <= vcs_pkg::SPEED_W'(2048);
            r_cfg.yaw_speed_lim             <= vcs_pkg::SPEED_W'(4096);
            r_cfg.max_linear_accel          <= vcs_pkg::ACCEL_W'(4096);
            r_cfg.max_lateral_accel         <= vcs_pkg::ACCEL_W'(4096);
            r_cfg.max_angular_accel         <= vcs_pkg::ACCEL_W'(8192);
            r_cfg.lateral_decoupling_enable <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                vcs_pkg::CFG_FWD_SPEED_LIM: begin
                    r_cfg.fwd_speed_lim <= i_cfg_data[vcs_pkg::SPEED_W-1:0];
                end
                vcs_pkg::CFG_SIDE_SPEED_LIM: begin
                    r_cfg.side_speed_lim <= i_cfg_data[vcs_pkg::SPEED_W-1:0];
                end
                vcs_pkg::CFG_YAW_SPEED_LIM: begin
                    r_cfg.yaw_speed_lim <= i_cfg_data[vcs_pkg::SPEED_W-1:0];
                end
                vcs_pkg::CFG_MAX_LINEAR_ACCEL: begin
                    r_cfg.max_linear_accel <= i_cfg_data[vcs_pkg::ACCEL_W-1:0];
                end
                vcs_pkg::CFG_MAX_LATERAL_ACCEL: begin
                    r_cfg.max_lateral_accel <= i_cfg_data[vcs_pkg::ACCEL_W-1:0];
                end
                vcs_pkg::CFG_MAX_ANGULAR_ACCEL: begin
                    r_cfg.max_angular_accel <= i_cfg_data[vcs_pkg::ACCEL_W-1:0];
                end
                vcs_pkg::CFG_DECOUPLE_ENABLE: begin
                    r_cfg.lateral_decoupling_enable <= i_cfg_data[0];
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== rtl/vcs_alu.sv =====
// Shared arithmetic unit: a 32 by 16 multiplier and one restoring divide step, registered.
module vcs_alu (
    input  logic                            i_clk,
    input  vcs_pkg::t_alu_req               i_req,
    output logic [vcs_pkg::ALU_RES_W-1:0]   o_res
);

    logic [vcs_pkg::ALU_RES_W-1:0] r_res;
    logic [vcs_pkg::ALU_RES_W-1:0] n_res;
    logic [vcs_pkg::ALU_A_W-1:0]   w_sub;
    logic                          w_ge;

    assign w_ge  = (i_req.a >= i_req.b);
    assign w_sub = i_req.a - i_req.b;

    always_comb begin
        case (i_req.op)
            vcs_pkg::ALU_MUL: begin
                n_res = vcs_pkg::ALU_RES_W'(i_req.a) * vcs_pkg::ALU_RES_W'(i_req.b[15:0]);
            end
            vcs_pkg::ALU_DIV: begin
                // Quotient bit sits just above the new partial remainder.
                n_res = {15'd0, w_ge, (w_ge ? w_sub : i_req.a)};
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
    end

    assign o_res = r_res;

endmodule

// ===== rtl/velocity_command_smoother.sv =====
// Top level of the velocity command smoother: sequencer and per-axis datapath.
//
// Channel   Direction  Handshake               Payload
// input     in         i_valid / o_ready       i_in   (t_cmd_in)
// result    out        o_valid / i_ready       o_out  (t_cmd_out)
// config    in         i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// With lateral decoupling on, a command runs the 15-step serial divide in the shared
// unit, then three multiply/slew passes, which a bypassed step skips; without it only
// the passes run, or none when bypassed. No new command is taken until the sequencer
// is back in idle. Reset is synchronous and returns the limits to their defaults and
// the history to zero with the next step treated as the first. The sequencer stalls
// in its finish state only while a result still waits.
module velocity_command_smoother #(
    parameter logic [vcs_pkg::BAND_W-1:0] FWD_BAND  = vcs_pkg::FWD_BAND_DEF,
    parameter logic [vcs_pkg::BAND_W-1:0] SIDE_BAND = vcs_pkg::SIDE_BAND_DEF,
    parameter logic [vcs_pkg::BAND_W-1:0] YAW_BAND  = vcs_pkg::YAW_BAND_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  vcs_pkg::t_cmd_in                i_in,
    output logic                            o_valid,
    input  logic                            i_ready,
    output vcs_pkg::t_cmd_out               o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [vcs_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [vcs_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int VW = vcs_pkg::VEL_W;
    localparam int SW = vcs_pkg::SPEED_W;
    localparam int QW = vcs_pkg::QUOT_W;

    vcs_pkg::t_cfg      w_cfg;
    vcs_pkg::t_alu_req  w_alu_req;
    logic [vcs_pkg::ALU_RES_W-1:0] w_alu_res;

    vcs_pkg::t_state    r_state;
    vcs_pkg::t_state    n_state;

    vcs_pkg::t_cmd_in   r_in;
    vcs_pkg::t_vel      r_tgt  [3];
    vcs_pkg::t_vel      r_last [3];
    vcs_pkg::t_vel      r_res  [3];
    logic               r_first;
    logic [1:0]         r_axis;
    logic [3:0]         r_cnt;
    logic [vcs_pkg::SQ_W-1:0] r_m2;
    logic [vcs_pkg::SQ_W-1:0] r_rem;
    logic [QW-1:0]      r_num;
    logic [QW-1:0]      r_q;
    logic               r_out_valid;
    vcs_pkg::t_cmd_out  r_out;

    logic               w_decouple;
    logic               w_bypass;
    logic               w_out_free;
    logic [QW-1:0]      w_q_next;
    logic [SW-1:0]      w_abs_yaw;
    logic [SW-1:0]      w_abs_lat;
    logic [vcs_pkg::SQ_W-1:0] w_div_rem;
    logic [SW-1:0]      w_vmax;
    logic [vcs_pkg::ACCEL_W-1:0] w_acc;
    vcs_pkg::t_vel      w_slew;

    function automatic vcs_pkg::t_vel f_clamp(input vcs_pkg::t_vel v,
                                              input logic [14:0] lim);
        logic signed [16:0] v17;
        logic signed [16:0] l17;
        logic signed [16:0] nl17;
        begin
            v17  = {v[15], v};
            l17  = $signed({2'b00, lim});
            nl17 = -l17;
            if (v17 > l17) begin
                f_clamp = l17[15:0];
            end else if (v17 < nl17) begin
                f_clamp = nl17[15:0];
            end else begin
                f_clamp = v;
            end
        end
    endfunction

    // Clamped values never reach the most negative code, so the magnitude fits 15 bits.
    function automatic logic [14:0] f_abs(input vcs_pkg::t_vel v);
        vcs_pkg::t_vel n;
        begin
            n = -v;
            f_abs = v[15] ? n[14:0] : v[14:0];
        end
    endfunction

    function automatic vcs_pkg::t_vel f_band(input vcs_pkg::t_vel v,
                                             input logic [11:0] band);
        logic signed [16:0] v17;
        logic signed [16:0] mag;
        begin
            v17 = {v[15], v};
            mag = v17[16] ? -v17 : v17;
            f_band = (mag < $signed({5'd0, band})) ? '0 : v;
        end
    endfunction

    vcs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (w_cfg)
    );

    vcs_alu u_alu (
        .i_clk (i_clk),
        .i_req (w_alu_req),
        .o_res (w_alu_res)
    );

    assign w_decouple = w_cfg.lateral_decoupling_enable
                      && (w_cfg.yaw_speed_lim > vcs_pkg::DECOUPLE_MIN);
    assign w_bypass   = r_first || r_in.restart || (r_in.step_time == '0);
    assign w_out_free = !r_out_valid || i_ready;
    assign w_q_next   = {r_q[QW-2:0], w_alu_res[32]};
    assign w_abs_yaw  = f_abs(r_tgt[2]);
    assign w_abs_lat  = f_abs(r_tgt[1]);
    assign w_div_rem  = (r_cnt == '0) ? r_rem : w_alu_res[vcs_pkg::SQ_W-1:0];

    always_comb begin
        case (r_axis)
            2'd0: begin
                w_vmax = w_cfg.fwd_speed_lim;
                w_acc  = w_cfg.max_linear_accel;
            end
            2'd1: begin
                w_vmax = w_cfg.side_speed_lim;
                w_acc  = w_cfg.max_lateral_accel;
            end
            2'd2: begin
                w_vmax = w_cfg.yaw_speed_lim;
                w_acc  = w_cfg.max_angular_accel;
            end
            default: begin
                w_vmax = '0;
                w_acc  = '0;
            end
        endcase
    end

    // Slew limit of the selected axis; the multiplier holds acc * dt.
    always_comb begin
        logic [15:0]        dv;
        logic signed [17:0] dv18;
        logic signed [17:0] ndv18;
        logic signed [17:0] last18;
        logic signed [17:0] diff;
        logic signed [17:0] step;
        logic signed [17:0] sum;
        logic signed [17:0] vm18;
        logic signed [17:0] nvm18;
        dv     = w_alu_res[31:16];
        if (dv < vcs_pkg::STEP_FLOOR) begin
            dv = vcs_pkg::STEP_FLOOR;
        end
        dv18   = $signed({2'b00, dv});
        ndv18  = -dv18;
        last18 = {{2{r_last[r_axis][VW-1]}}, r_last[r_axis]};
        diff   = {{2{r_tgt[r_axis][VW-1]}}, r_tgt[r_axis]} - last18;
        if (diff > dv18) begin
            step = dv18;
        end else if (diff < ndv18) begin
            step = ndv18;
        end else begin
            step = diff;
        end
        sum   = last18 + step;
        vm18  = $signed({3'b000, w_vmax});
        nvm18 = -vm18;
        if (sum > vm18) begin
            w_slew = vm18[VW-1:0];
        end else if (sum < nvm18) begin
            w_slew = nvm18[VW-1:0];
        end else begin
            w_slew = sum[VW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            vcs_pkg::ST_IDLE: begin
                if (i_valid) begin
                    n_state = vcs_pkg::ST_CLAMP;
                end
            end
            vcs_pkg::ST_CLAMP: begin
                n_state = w_decouple ? vcs_pkg::ST_SQ_MAX : vcs_pkg::ST_ROUTE;
            end
            vcs_pkg::ST_SQ_MAX:   n_state = vcs_pkg::ST_SQ_YAW;
            vcs_pkg::ST_SQ_YAW:   n_state = vcs_pkg::ST_MUL_LAT;
            vcs_pkg::ST_MUL_LAT:  n_state = vcs_pkg::ST_LOAD_DIV;
            vcs_pkg::ST_LOAD_DIV: n_state = vcs_pkg::ST_DIV;
            vcs_pkg::ST_DIV: begin
                if (r_cnt == 4'(QW - 1)) begin
                    n_state = vcs_pkg::ST_DIV_LAST;
                end
            end
            vcs_pkg::ST_DIV_LAST: n_state = vcs_pkg::ST_ROUTE;
            vcs_pkg::ST_ROUTE: begin
                n_state = w_bypass ? vcs_pkg::ST_FINISH : vcs_pkg::ST_MUL_STEP;
            end
            vcs_pkg::ST_MUL_STEP: n_state = vcs_pkg::ST_SLEW;
            vcs_pkg::ST_SLEW: begin
                n_state = (r_axis == 2'd2) ? vcs_pkg::ST_FINISH : vcs_pkg::ST_MUL_STEP;
            end
            vcs_pkg::ST_FINISH: begin
                if (w_out_free) begin
                    n_state = vcs_pkg::ST_IDLE;
                end
            end
            default: n_state = vcs_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_ready      = 1'b0;
        w_alu_req.op = vcs_pkg::ALU_MUL;
        w_alu_req.a  = '0;
        w_alu_req.b  = '0;
        case (r_state)
            vcs_pkg::ST_IDLE: begin
                o_ready = 1'b1;
            end
            vcs_pkg::ST_SQ_MAX: begin
                w_alu_req.a = 32'(w_cfg.yaw_speed_lim);
                w_alu_req.b = 32'(w_cfg.yaw_speed_lim);
            end
            vcs_pkg::ST_SQ_YAW: begin
                w_alu_req.a = 32'(w_abs_yaw);
                w_alu_req.b = 32'(w_abs_yaw);
            end
            vcs_pkg::ST_MUL_LAT: begin
                // The yaw target never exceeds its limit, so this difference is not negative.
                w_alu_req.a = 32'(r_m2 - w_alu_res[vcs_pkg::SQ_W-1:0]);
                w_alu_req.b = 32'(w_abs_lat);
            end
            vcs_pkg::ST_DIV: begin
                w_alu_req.op = vcs_pkg::ALU_DIV;
                w_alu_req.a  = 32'({w_div_rem, r_num[QW-1]});
                w_alu_req.b  = 32'(r_m2);
            end
            vcs_pkg::ST_MUL_STEP: begin
                w_alu_req.a = 32'(w_acc);
                w_alu_req.b = 32'(r_in.step_time);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= vcs_pkg::ST_IDLE;
            r_first     <= 1'b1;
            r_out_valid <= 1'b0;
            r_axis      <= '0;
            r_cnt       <= '0;
            for (int i = 0; i < 3; i++) begin
                r_last[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if ((r_state == vcs_pkg::ST_FINISH) && w_out_free) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                vcs_pkg::ST_IDLE: begin
                    if (i_valid) begin
                        r_in <= i_in;
                    end
                end
                vcs_pkg::ST_CLAMP: begin
                    r_tgt[0] <= f_clamp(r_in.target_linear_x,  w_cfg.fwd_speed_lim);
                    r_tgt[1] <= f_clamp(r_in.target_lateral_y, w_cfg.side_speed_lim);
                    r_tgt[2] <= f_clamp(r_in.target_angular_z, w_cfg.yaw_speed_lim);
                end
                vcs_pkg::ST_SQ_YAW: begin
                    r_m2 <= w_alu_res[vcs_pkg::SQ_W-1:0];
                end
                vcs_pkg::ST_LOAD_DIV: begin
                    // The quotient stays below 2^15, so the top bits start below the divisor.
                    r_rem <= w_alu_res[vcs_pkg::SQ_W+QW-1:QW];
                    r_num <= w_alu_res[QW-1:0];
                    r_cnt <= '0;
                end
                vcs_pkg::ST_DIV: begin
                    r_num <= {r_num[QW-2:0], 1'b0};
                    r_cnt <= r_cnt + 4'd1;
                    if (r_cnt != '0) begin
                        r_q <= w_q_next;
                    end
                end
                vcs_pkg::ST_DIV_LAST: begin
                    r_tgt[1] <= r_tgt[1][VW-1] ? -$signed({1'b0, w_q_next})
                                               :  $signed({1'b0, w_q_next});
                end
                vcs_pkg::ST_ROUTE: begin
                    r_axis <= '0;
                    if (w_bypass) begin
                        for (int i = 0; i < 3; i++) begin
                            r_res[i] <= r_tgt[i];
                        end
                    end
                end
                vcs_pkg::ST_SLEW: begin
                    r_res[r_axis] <= w_slew;
                    r_axis        <= r_axis + 2'd1;
                end
                vcs_pkg::ST_FINISH: begin
                    if (w_out_free) begin
                        r_first     <= 1'b0;
                        for (int i = 0; i < 3; i++) begin
                            r_last[i] <= r_res[i];
                        end
                        r_out.out_linear_x  <= f_band(r_res[0], FWD_BAND);
                        r_out.out_lateral_y <= f_band(r_res[1], SIDE_BAND);
                        r_out.out_angular_z <= f_band(r_res[2], YAW_BAND);
                    end
                end
                default: begin
                end
            endcase
        end
    end

    assign o_valid = r_out_valid;
    assign o_out   = r_out;

endmodule
